### hw/rtl/usm_pkg.sv
// Shared types, constants and widths of the UV sphere mesh generator.
`default_nettype none
package usm_pkg;

    localparam int COUNT_W  = 9;
    localparam int RADIUS_W = 31;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STACKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTORS = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 31'd65536;
    localparam logic [COUNT_W-1:0]  STACKS_RESET  = 9'd16;
    localparam logic [COUNT_W-1:0]  SECTORS_RESET = 9'd32;

    // Largest stack and sector counts that the datapath widths support.
    localparam logic [COUNT_W-1:0]  MAX_STACKS  = 9'd256;
    localparam logic [COUNT_W-1:0]  MAX_SECTORS = 9'd256;

    // Phases are fractions of a full turn with 24 fractional bits.
    localparam int PH_W = 24;
    localparam logic [PH_W-1:0] QUARTER = 24'h40_0000;

    // Sine values and polynomial terms are unsigned Q30 below 2^31.
    localparam int Q30_W = 31;
    localparam logic [Q30_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [Q30_W-1:0] K1 = 31'd1686629713;
    localparam logic [Q30_W-1:0] K3 = 31'd693598669;
    localparam logic [Q30_W-1:0] K5 = 31'd85569306;
    localparam logic [Q30_W-1:0] K7 = 31'd5026995;
    localparam logic [Q30_W-1:0] K9 = 31'd172272;

    // Divider geometry shared by all four quotient lanes.
    localparam int DIV_NUM_W = 36;
    localparam int DIV_DEN_W = 10;
    localparam int DIV_BPS   = 4;
    localparam int DIV_LAT   = DIV_NUM_W / DIV_BPS;

    localparam int SIN_LAT   = 7;
    localparam int SCALE_LAT = 4;

    localparam int TEX_W = 17;
    localparam int IDX_W = 19;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] stack_index;
        logic [COUNT_W-1:0] sector_index;
    } point_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] x_or_first;
        logic signed [31:0] y_or_second;
        logic signed [31:0] z_or_third;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [TEX_W-1:0]   tex_u;
        logic [TEX_W-1:0]   tex_v;
        logic               range_error;
        logic               last;
    } result_t;

    typedef struct packed {
        logic             err;
        logic             up;
        logic             dn;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
    } cell_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } vertex_t;

endpackage
`default_nettype wire

### hw/rtl/usm_div.sv
// Pipelined restoring divider, several quotient bits per stage.
`default_nettype none
module usm_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 10,
    parameter int BPS   = 4
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo
);

    localparam int STAGES = NUM_W / BPS;

    logic [DEN_W-1:0] rem_reg  [STAGES];
    logic [NUM_W-1:0] acc_reg  [STAGES];
    logic [DEN_W-1:0] rem_next [STAGES];
    logic [NUM_W-1:0] acc_next [STAGES];

    // The accumulator shifts the dividend out at the top and the quotient in at the bottom.
    always_comb
    begin
        logic [DEN_W-1:0] r;
        logic [NUM_W-1:0] a;
        logic [DEN_W:0]   t;
        for (int s = 0; s < STAGES; s++)
        begin
            r = (s == 0) ? '0 : rem_reg[(s == 0) ? 0 : s - 1];
            a = (s == 0) ? num : acc_reg[(s == 0) ? 0 : s - 1];
            for (int b = 0; b < BPS; b++)
            begin
                t = {r, a[NUM_W-1]};
                a = {a[NUM_W-2:0], 1'b0};
                if (t >= {1'b0, den})
                begin
                    t    = t - {1'b0, den};
                    a[0] = 1'b1;
                end
                r = t[DEN_W-1:0];
            end
            rem_next[s] = r;
            acc_next[s] = a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                acc_reg[s] <= acc_next[s];
            end
        end
    end

    assign quo = acc_reg[STAGES-1];

endmodule
`default_nettype wire

### hw/rtl/usm_sin.sv
// Pipelined sine of a phase in turns by a folded odd polynomial in Q30.
`default_nettype none
module usm_sin (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [usm_pkg::PH_W-1:0] phase,
    output logic signed [31:0]            sine
);

    localparam logic [usm_pkg::Q30_W-1:0] COEF [4] =
        '{usm_pkg::K7, usm_pkg::K5, usm_pkg::K3, usm_pkg::K1};

    logic [usm_pkg::Q30_W-1:0] t_reg   [6];
    logic                      neg_reg [6];
    logic [usm_pkg::Q30_W-1:0] t2_reg  [4];
    logic [usm_pkg::Q30_W-1:0] h_reg   [4];
    logic signed [31:0]        sine_reg;

    logic [22:0]               x_next;
    logic [61:0]               sq;
    logic [61:0]               hp     [4];
    logic [61:0]               fp;
    logic [usm_pkg::Q30_W-1:0] hs;
    logic [31:0]               mag;

    // Fold the phase onto the first quarter wave; the top bit gives the sign.
    always_comb
    begin
        x_next = phase[22] ? (23'(usm_pkg::QUARTER) - {1'b0, phase[21:0]})
                           : {1'b0, phase[21:0]};
        sq     = t_reg[0] * t_reg[0];
        hp[0]  = t2_reg[0] * usm_pkg::K9;
        for (int k = 1; k < 4; k++)
        begin
            hp[k] = t2_reg[k] * h_reg[k-1];
        end
        fp  = t_reg[5] * h_reg[3];
        hs  = (fp[60:30] > usm_pkg::ONE_Q30) ? usm_pkg::ONE_Q30 : fp[60:30];
        mag = {1'b0, hs};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]   <= {x_next, 8'b0};
            neg_reg[0] <= phase[23];
            for (int s = 1; s < 6; s++)
            begin
                t_reg[s]   <= t_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
            t2_reg[0] <= sq[60:30];
            for (int k = 1; k < 4; k++)
            begin
                t2_reg[k] <= t2_reg[k-1];
            end
            for (int k = 0; k < 4; k++)
            begin
                h_reg[k] <= COEF[k] - hp[k][60:30];
            end
            sine_reg <= neg_reg[5] ? -mag : mag;
        end
    end

    assign sine = sine_reg;

endmodule
`default_nettype wire

### hw/rtl/usm_scale.sv
// Position and normal products with round-to-nearest, four stages.
`default_nettype none
module usm_scale (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [usm_pkg::RADIUS_W-1:0] radius,
    input  wire logic signed [31:0]           cu,
    input  wire logic signed [31:0]           su,
    input  wire logic signed [31:0]           cv,
    input  wire logic signed [31:0]           sv,
    output usm_pkg::vertex_t                  vtx
);

    function automatic logic [30:0] mag31(input logic signed [31:0] v);
        logic [31:0] n;
        n = -v;
        return v[31] ? n[30:0] : v[30:0];
    endfunction

    function automatic logic signed [31:0] rnd30(input logic [61:0] p, input logic neg);
        logic [61:0] s;
        logic [31:0] m;
        s = p + (62'd1 << 29);
        m = {1'b0, s[60:30]};
        return neg ? -m : m;
    endfunction

    function automatic logic signed [15:0] rnd46(input logic [61:0] p, input logic neg);
        logic [61:0] s;
        logic [15:0] m;
        s = p + (62'd1 << 45);
        m = s[61:46];
        return neg ? -m : m;
    endfunction

    // Stage one: magnitude products.
    logic [61:0]        p_xy_reg, p_z_reg, p_nx_reg, p_ny_reg;
    logic               s_xy_reg, s_z_reg, s_nx_reg, s_ny_reg;
    logic signed [31:0] su1_reg;
    logic [30:0]        cvm1_reg, svm1_reg;
    logic               cvs1_reg, svs1_reg;
    // Stage two: rounded first products.
    logic [30:0]        xym2_reg;
    logic               xys2_reg;
    logic signed [31:0] z2_reg;
    logic signed [15:0] nx2_reg, ny2_reg, nz2_reg;
    logic [30:0]        cvm2_reg, svm2_reg;
    logic               cvs2_reg, svs2_reg;
    // Stage three: second products.
    logic [61:0]        p_x_reg, p_y_reg;
    logic               s_x_reg, s_y_reg;
    logic signed [31:0] z3_reg;
    logic signed [15:0] nx3_reg, ny3_reg, nz3_reg;
    // Stage four: result.
    usm_pkg::vertex_t   vtx_reg;

    logic [30:0] cum, sum_m, cvm, svm, su1m;
    logic [31:0] nz_sum;
    logic [15:0] nz_m;

    always_comb
    begin
        cum    = mag31(cu);
        sum_m  = mag31(su);
        cvm    = mag31(cv);
        svm    = mag31(sv);
        su1m   = mag31(su1_reg);
        nz_sum = {1'b0, su1m} + 32'h0000_8000;
        nz_m   = nz_sum[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_xy_reg <= radius * cum;
            s_xy_reg <= cu[31];
            p_z_reg  <= radius * sum_m;
            s_z_reg  <= su[31];
            p_nx_reg <= cum * cvm;
            s_nx_reg <= cu[31] ^ cv[31];
            p_ny_reg <= cum * svm;
            s_ny_reg <= cu[31] ^ sv[31];
            su1_reg  <= su;
            cvm1_reg <= cvm;
            cvs1_reg <= cv[31];
            svm1_reg <= svm;
            svs1_reg <= sv[31];

            xym2_reg <= 31'(rnd30(p_xy_reg, 1'b0));
            xys2_reg <= s_xy_reg;
            z2_reg   <= rnd30(p_z_reg, s_z_reg);
            nx2_reg  <= rnd46(p_nx_reg, s_nx_reg);
            ny2_reg  <= rnd46(p_ny_reg, s_ny_reg);
            nz2_reg  <= su1_reg[31] ? -nz_m : nz_m;
            cvm2_reg <= cvm1_reg;
            cvs2_reg <= cvs1_reg;
            svm2_reg <= svm1_reg;
            svs2_reg <= svs1_reg;

            p_x_reg <= xym2_reg * cvm2_reg;
            s_x_reg <= xys2_reg ^ cvs2_reg;
            p_y_reg <= xym2_reg * svm2_reg;
            s_y_reg <= xys2_reg ^ svs2_reg;
            z3_reg  <= z2_reg;
            nx3_reg <= nx2_reg;
            ny3_reg <= ny2_reg;
            nz3_reg <= nz2_reg;

            vtx_reg.x  <= rnd30(p_x_reg, s_x_reg);
            vtx_reg.y  <= rnd30(p_y_reg, s_y_reg);
            vtx_reg.z  <= z3_reg;
            vtx_reg.nx <= nx3_reg;
            vtx_reg.ny <= ny3_reg;
            vtx_reg.nz <= nz3_reg;
        end
    end

    assign vtx = vtx_reg;

endmodule
`default_nettype wire

### hw/rtl/usm_emit.sv
// Output stage: holds one grid point and hands out its results one at a time.
`default_nettype none
module usm_emit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    input  wire usm_pkg::cell_t            geom,
    input  wire usm_pkg::vertex_t          vtx,
    input  wire logic [usm_pkg::TEX_W-1:0] tu,
    input  wire logic [usm_pkg::TEX_W-1:0] tv,
    output logic                           advance,
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output usm_pkg::result_t               result
);

    logic                      hold_reg;
    logic                      vtx_pend_reg;
    logic                      up_reg;
    logic                      dn_reg;
    usm_pkg::cell_t            cell_reg;
    usm_pkg::vertex_t          vtx_reg;
    logic [usm_pkg::TEX_W-1:0] tu_reg;
    logic [usm_pkg::TEX_W-1:0] tv_reg;

    logic             is_last;
    logic [usm_pkg::IDX_W-1:0] first_inc;
    logic [usm_pkg::IDX_W-1:0] second_inc;

    always_comb
    begin
        if (vtx_pend_reg)
        begin
            is_last = !(up_reg || dn_reg);
        end
        else if (up_reg)
        begin
            is_last = !dn_reg;
        end
        else
        begin
            is_last = 1'b1;
        end
        advance = !hold_reg || (!result_stall && is_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= 1'b0;
            vtx_pend_reg <= 1'b0;
            up_reg       <= 1'b0;
            dn_reg       <= 1'b0;
        end
        else if (advance)
        begin
            hold_reg     <= item_valid;
            vtx_pend_reg <= 1'b1;
            up_reg       <= geom.up;
            dn_reg       <= geom.dn;
        end
        else if (!result_stall)
        begin
            // A result other than the last one was taken.
            if (vtx_pend_reg)
            begin
                vtx_pend_reg <= 1'b0;
            end
            else
            begin
                up_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cell_reg <= geom;
            vtx_reg  <= vtx;
            tu_reg   <= tu;
            tv_reg   <= tv;
        end
    end

    always_comb
    begin
        first_inc  = cell_reg.first + 1'b1;
        second_inc = cell_reg.second + 1'b1;
        result     = '0;
        result.last = is_last;
        if (cell_reg.err)
        begin
            result.range_error = 1'b1;
        end
        else if (vtx_pend_reg)
        begin
            result.kind        = usm_pkg::KIND_VERTEX;
            result.x_or_first  = vtx_reg.x;
            result.y_or_second = vtx_reg.y;
            result.z_or_third  = vtx_reg.z;
            result.normal_x    = vtx_reg.nx;
            result.normal_y    = vtx_reg.ny;
            result.normal_z    = vtx_reg.nz;
            result.tex_u       = tu_reg;
            result.tex_v       = tv_reg;
        end
        else if (up_reg)
        begin
            result.kind        = usm_pkg::KIND_TRIANGLE;
            result.x_or_first  = 32'(cell_reg.first);
            result.y_or_second = 32'(cell_reg.second);
            result.z_or_third  = 32'(first_inc);
        end
        else
        begin
            result.kind        = usm_pkg::KIND_TRIANGLE;
            result.x_or_first  = 32'(first_inc);
            result.y_or_second = 32'(cell_reg.second);
            result.z_or_third  = 32'(second_inc);
        end
    end

    assign result_valid = hold_reg;

endmodule
`default_nettype wire

### hw/rtl/uv_sphere_mesh_generator.sv
// Top level of the UV sphere mesh generator: configuration, pipeline and output stage.
//
// The point channel (point_valid, point_stall, point) carries one grid point
// (stack row, sector column) per transaction. The result channel (result_valid,
// result_stall, result) returns the vertex of that point and then, for a cell
// inside the grid, its upper (not in row 0) and lower (not in the last row)
// triangles; the final result of a point carries last. A point outside the
// configured counts yields one result with only range_error and last set.
// The write port (wr_en, wr_index, wr_data) sets radius, stack count and sector
// count; write it only while no transaction is in flight.
// The first result of a point is shown once it has passed one input stage, nine
// divider stages, seven sine stages and four product stages and loaded the
// output stage. A new point enters every cycle unless point_stall is high; a
// point holds the output stage until all of its results (one to three) are
// taken, so the result channel, one result per cycle while result_stall is low,
// sets the sustained rate.
// When the receiver stalls a valid result, the whole pipeline holds in place
// and point_stall rises; nothing is dropped or repeated. Reset empties the
// pipeline and loads radius 1.0, 16 stacks and 32 sectors.
`default_nettype none
module uv_sphere_mesh_generator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [usm_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [usm_pkg::CFG_W-1:0]     wr_data,
    input  wire logic                          point_valid,
    output logic                               point_stall,
    input  wire usm_pkg::point_t               point,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output usm_pkg::result_t                   result
);

    localparam int META_LAT = usm_pkg::DIV_LAT + usm_pkg::SIN_LAT + usm_pkg::SCALE_LAT;
    localparam int TEX_LAT  = usm_pkg::SIN_LAT + usm_pkg::SCALE_LAT;
    localparam int CW       = usm_pkg::COUNT_W;

    // Configuration registers.
    logic [usm_pkg::RADIUS_W-1:0] radius_reg;
    logic [CW-1:0]                stack_count_reg;
    logic [CW-1:0]                sector_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg       <= usm_pkg::RADIUS_RESET;
            stack_count_reg  <= usm_pkg::STACKS_RESET;
            sector_count_reg <= usm_pkg::SECTORS_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                usm_pkg::REG_RADIUS:  radius_reg       <= wr_data;
                usm_pkg::REG_STACKS:  stack_count_reg  <= wr_data[CW-1:0];
                usm_pkg::REG_SECTORS: sector_count_reg <= wr_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Counts in use, kept between one and the supported maximum.
    logic [CW-1:0] st;
    logic [CW-1:0] se;

    always_comb
    begin
        if (stack_count_reg == '0)
            st = CW'(1);
        else if (stack_count_reg > usm_pkg::MAX_STACKS)
            st = usm_pkg::MAX_STACKS;
        else
            st = stack_count_reg;
        if (sector_count_reg == '0)
            se = CW'(1);
        else if (sector_count_reg > usm_pkg::MAX_SECTORS)
            se = usm_pkg::MAX_SECTORS;
        else
            se = sector_count_reg;
    end

    logic advance;
    assign point_stall = !advance;

    // Input stage.
    logic          a_valid_reg;
    logic [CW-1:0] a_i_reg;
    logic [CW-1:0] a_j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (advance)
            a_valid_reg <= point_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_i_reg <= point.stack_index;
            a_j_reg <= point.sector_index;
        end
    end

    // Cell classification and triangle indices of the point in the input stage.
    usm_pkg::cell_t cell_a;
    logic           cell_in;
    logic [usm_pkg::IDX_W-1:0] row_base;

    always_comb
    begin
        cell_in       = (a_i_reg < st) && (a_j_reg < se);
        row_base      = a_i_reg * ({1'b0, se} + 1'b1);
        cell_a.err    = (a_i_reg > st) || (a_j_reg > se);
        cell_a.up     = cell_in && (a_i_reg != '0);
        cell_a.dn     = cell_in && (a_i_reg != st - 1'b1);
        cell_a.first  = row_base + usm_pkg::IDX_W'(a_j_reg);
        cell_a.second = cell_a.first + usm_pkg::IDX_W'(se) + 1'b1;
    end

    // Dividers: polar phase, azimuth phase and the two texture coordinates.
    logic [usm_pkg::DIV_NUM_W-1:0] q_pp, q_pv, q_tu, q_tv;

    usm_div #(.NUM_W(usm_pkg::DIV_NUM_W), .DEN_W(usm_pkg::DIV_DEN_W),
              .BPS(usm_pkg::DIV_BPS)) u_div_pp (
        .clk (clk), .en (advance),
        .num (usm_pkg::DIV_NUM_W'({a_i_reg, 24'b0}) + usm_pkg::DIV_NUM_W'(st)),
        .den ({st, 1'b0}),
        .quo (q_pp)
    );

    usm_div #(.NUM_W(usm_pkg::DIV_NUM_W), .DEN_W(usm_pkg::DIV_DEN_W),
              .BPS(usm_pkg::DIV_BPS)) u_div_pv (
        .clk (clk), .en (advance),
        .num (usm_pkg::DIV_NUM_W'({a_j_reg, 24'b0}) + usm_pkg::DIV_NUM_W'(se >> 1)),
        .den ({1'b0, se}),
        .quo (q_pv)
    );

    usm_div #(.NUM_W(usm_pkg::DIV_NUM_W), .DEN_W(usm_pkg::DIV_DEN_W),
              .BPS(usm_pkg::DIV_BPS)) u_div_tu (
        .clk (clk), .en (advance),
        .num (usm_pkg::DIV_NUM_W'({a_j_reg, 16'b0}) + usm_pkg::DIV_NUM_W'(se >> 1)),
        .den ({1'b0, se}),
        .quo (q_tu)
    );

    usm_div #(.NUM_W(usm_pkg::DIV_NUM_W), .DEN_W(usm_pkg::DIV_DEN_W),
              .BPS(usm_pkg::DIV_BPS)) u_div_tv (
        .clk (clk), .en (advance),
        .num (usm_pkg::DIV_NUM_W'({a_i_reg, 16'b0}) + usm_pkg::DIV_NUM_W'(st >> 1)),
        .den ({1'b0, st}),
        .quo (q_tv)
    );

    // Sines: cos(u) is the sine of the polar phase and sin(u) its cosine.
    logic [usm_pkg::PH_W-1:0] pp, pv;
    logic signed [31:0]       cu, su, cv, sv;

    assign pp = q_pp[usm_pkg::PH_W-1:0];
    assign pv = q_pv[usm_pkg::PH_W-1:0];

    usm_sin u_sin_cu (.clk (clk), .en (advance), .phase (pp), .sine (cu));
    usm_sin u_sin_su (.clk (clk), .en (advance), .phase (pp + usm_pkg::QUARTER), .sine (su));
    usm_sin u_sin_cv (.clk (clk), .en (advance), .phase (pv + usm_pkg::QUARTER), .sine (cv));
    usm_sin u_sin_sv (.clk (clk), .en (advance), .phase (pv), .sine (sv));

    usm_pkg::vertex_t vtx;

    usm_scale u_scale (
        .clk    (clk),
        .en     (advance),
        .radius (radius_reg),
        .cu     (cu),
        .su     (su),
        .cv     (cv),
        .sv     (sv),
        .vtx    (vtx)
    );

    // Side lines that keep valid bits, cell data and texture in step with the datapath.
    logic [META_LAT-1:0]       valid_pipe_reg;
    usm_pkg::cell_t            cell_pipe_reg [META_LAT];
    logic [usm_pkg::TEX_W-1:0] tu_pipe_reg   [TEX_LAT];
    logic [usm_pkg::TEX_W-1:0] tv_pipe_reg   [TEX_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_pipe_reg <= '0;
        else if (advance)
            valid_pipe_reg <= {valid_pipe_reg[META_LAT-2:0], a_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cell_pipe_reg[0] <= cell_a;
            for (int s = 1; s < META_LAT; s++)
            begin
                cell_pipe_reg[s] <= cell_pipe_reg[s-1];
            end
            tu_pipe_reg[0] <= q_tu[usm_pkg::TEX_W-1:0];
            tv_pipe_reg[0] <= q_tv[usm_pkg::TEX_W-1:0];
            for (int s = 1; s < TEX_LAT; s++)
            begin
                tu_pipe_reg[s] <= tu_pipe_reg[s-1];
                tv_pipe_reg[s] <= tv_pipe_reg[s-1];
            end
        end
    end

    usm_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (valid_pipe_reg[META_LAT-1]),
        .geom         (cell_pipe_reg[META_LAT-1]),
        .vtx          (vtx),
        .tu           (tu_pipe_reg[TEX_LAT-1]),
        .tv           (tv_pipe_reg[TEX_LAT-1]),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire
